[src/csscp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csscp_pkg: shared types and constants of the CSS color string parser
// Holds the channel payload types, the parse form codes, the status codes
// and the snapshot that the parser hands to the result stage.
// ----------------------------------------------------------------------------
package csscp_pkg;

  localparam logic [2:0] FORM_START  = 3'd0;
  localparam logic [2:0] FORM_HEX    = 3'd1;
  localparam logic [2:0] FORM_PREFIX = 3'd2;
  localparam logic [2:0] FORM_BODY   = 3'd3;
  localparam logic [2:0] FORM_UNSUP  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HEX_LEN = 2'd1;
  localparam logic [1:0] ST_BAD_CH  = 2'd2;
  localparam logic [1:0] ST_UNSUP   = 2'd3;

  localparam int CompCnt = 3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] status;
  } out_t;

  // Parser state as it stands after the final character of a string
  typedef struct packed {
    logic [2:0]               form;
    logic [3:0]               hex_count;
    logic [31:0]              hex_digits;
    logic                     bad_char;
    logic [CompCnt-1:0][9:0]  comp_values;
    logic [CompCnt-1:0]       percent_marks;
  } fin_t;

endpackage

[src/csscp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csscp_parser: per-character parser state
// Updates the form, hex digit and rgb component registers on every accepted
// character and loads a snapshot register when the string ends.
// ----------------------------------------------------------------------------
module csscp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csscp_pkg::in_t    in_data,
  output logic              fin_valid,
  input  logic              fin_ready,
  output csscp_pkg::fin_t   fin
);

  localparam logic [1:0] NUM_IDLE  = 2'd0;
  localparam logic [1:0] NUM_WHOLE = 2'd1;
  localparam logic [1:0] NUM_FRAC  = 2'd2;
  localparam logic [1:0] NUM_EXTRA = 2'd3;

  logic [2:0]        form_r, form_nxt;
  logic [1:0]        prefix_pos_r, prefix_pos_nxt;
  logic [3:0]        hex_count_r, hex_count_nxt;
  logic [31:0]       hex_digits_r, hex_digits_nxt;
  logic              bad_char_r, bad_char_nxt;
  logic [1:0]        comp_index_r, comp_index_nxt;
  logic [2:0][9:0]   comp_values_r, comp_values_nxt;
  logic [1:0]        num_flags_r, num_flags_nxt;
  logic [2:0]        percent_r, percent_nxt;
  logic              fin_valid_r;
  csscp_pkg::fin_t   fin_r;

  logic              accept;
  logic [7:0]        c;
  logic [4:0]        hex_v;
  logic [1:0]        slot;
  logic [13:0]       acc10;

  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    v = 5'd16;
    if (ch >= "0" && ch <= "9") v = 5'(ch - "0");
    else if (ch >= "a" && ch <= "f") v = 5'(ch - "a" + 8'd10);
    else if (ch >= "A" && ch <= "F") v = 5'(ch - "A" + 8'd10);
    return v;
  endfunction

  assign in_ready  = !fin_valid_r || fin_ready;
  assign accept    = in_valid && in_ready;
  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;
  assign c         = in_data.ch;
  assign hex_v     = hex_value(c);
  assign slot      = comp_index_r - 2'd1;
  assign acc10     = {1'b0, comp_values_r[slot], 3'b000} + {3'b000, comp_values_r[slot], 1'b0}
                   + {10'd0, 4'(c - "0")};

  always_comb begin
    form_nxt        = form_r;
    prefix_pos_nxt  = prefix_pos_r;
    hex_count_nxt   = hex_count_r;
    hex_digits_nxt  = hex_digits_r;
    bad_char_nxt    = bad_char_r;
    comp_index_nxt  = comp_index_r;
    comp_values_nxt = comp_values_r;
    num_flags_nxt   = num_flags_r;
    percent_nxt     = percent_r;
    case (form_r)
      csscp_pkg::FORM_START: begin
        if (c == "#") begin
          form_nxt = csscp_pkg::FORM_HEX;
        end else if (c == "r") begin
          form_nxt       = csscp_pkg::FORM_PREFIX;
          prefix_pos_nxt = 2'd1;
        end else begin
          form_nxt = csscp_pkg::FORM_UNSUP;
        end
      end
      csscp_pkg::FORM_HEX: begin
        if (hex_v[4]) begin
          bad_char_nxt   = 1'b1;
          hex_digits_nxt = {hex_digits_r[27:0], 4'h0};
        end else begin
          hex_digits_nxt = {hex_digits_r[27:0], hex_v[3:0]};
        end
        if (hex_count_r != 4'd15) hex_count_nxt = hex_count_r + 4'd1;
      end
      csscp_pkg::FORM_PREFIX: begin
        if (prefix_pos_r == 2'd1 && c == "g") begin
          prefix_pos_nxt = 2'd2;
        end else if (prefix_pos_r == 2'd2 && c == "b") begin
          prefix_pos_nxt = 2'd3;
          form_nxt       = csscp_pkg::FORM_BODY;
        end else begin
          form_nxt = csscp_pkg::FORM_UNSUP;
        end
      end
      csscp_pkg::FORM_BODY: begin
        if (c inside {["0":"9"]}) begin
          if (num_flags_r == NUM_IDLE) begin
            if (comp_index_r != 2'd3) begin
              comp_values_nxt[comp_index_r] = {6'd0, 4'(c - "0")};
              comp_index_nxt = comp_index_r + 2'd1;
              num_flags_nxt  = NUM_WHOLE;
            end else begin
              num_flags_nxt = NUM_EXTRA;
            end
          end else if (num_flags_r == NUM_WHOLE && slot != 2'd3) begin
            // saturate the whole part at 1023
            comp_values_nxt[slot] = (acc10 > 14'd1023) ? 10'd1023 : acc10[9:0];
          end
        end else if (c == ".") begin
          if (num_flags_r == NUM_WHOLE) begin
            num_flags_nxt = NUM_FRAC;
          end else if (num_flags_r != NUM_EXTRA) begin
            // dot with no number in progress, or a second dot: new number
            if (comp_index_r != 2'd3) begin
              comp_values_nxt[comp_index_r] = 10'd0;
              comp_index_nxt = comp_index_r + 2'd1;
              num_flags_nxt  = NUM_FRAC;
            end else begin
              num_flags_nxt = NUM_EXTRA;
            end
          end
        end else if (c == "%") begin
          if ((num_flags_r == NUM_WHOLE || num_flags_r == NUM_FRAC) && slot != 2'd3) begin
            percent_nxt[slot] = 1'b1;
          end
          num_flags_nxt = NUM_IDLE;
        end else if (c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C,
                               "(", ")", ",", "r", "g", "b"}) begin
          num_flags_nxt = NUM_IDLE;
        end else begin
          bad_char_nxt  = 1'b1;
          num_flags_nxt = NUM_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      form_r        <= csscp_pkg::FORM_START;
      prefix_pos_r  <= 2'd0;
      hex_count_r   <= 4'd0;
      hex_digits_r  <= 32'd0;
      bad_char_r    <= 1'b0;
      comp_index_r  <= 2'd0;
      comp_values_r <= '0;
      num_flags_r   <= NUM_IDLE;
      percent_r     <= 3'd0;
    end else if (accept) begin
      if (in_data.last) begin
        // string done: start over for the next one
        form_r        <= csscp_pkg::FORM_START;
        prefix_pos_r  <= 2'd0;
        hex_count_r   <= 4'd0;
        hex_digits_r  <= 32'd0;
        bad_char_r    <= 1'b0;
        comp_index_r  <= 2'd0;
        comp_values_r <= '0;
        num_flags_r   <= NUM_IDLE;
        percent_r     <= 3'd0;
      end else begin
        form_r        <= form_nxt;
        prefix_pos_r  <= prefix_pos_nxt;
        hex_count_r   <= hex_count_nxt;
        hex_digits_r  <= hex_digits_nxt;
        bad_char_r    <= bad_char_nxt;
        comp_index_r  <= comp_index_nxt;
        comp_values_r <= comp_values_nxt;
        num_flags_r   <= num_flags_nxt;
        percent_r     <= percent_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (accept && in_data.last) begin
      fin_valid_r <= 1'b1;
    end else if (fin_ready) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last) begin
      fin_r.form          <= form_nxt;
      fin_r.hex_count     <= hex_count_nxt;
      fin_r.hex_digits    <= hex_digits_nxt;
      fin_r.bad_char      <= bad_char_nxt;
      fin_r.comp_values   <= comp_values_nxt;
      fin_r.percent_marks <= percent_nxt;
    end
  end

endmodule

[src/csscp_finish.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csscp_finish: color result stage
// Turns the parser snapshot into a color and status and holds it in the
// output register until the transaction completes.
// ----------------------------------------------------------------------------
module csscp_finish (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fin_valid,
  output logic              fin_ready,
  input  csscp_pkg::fin_t   fin,
  input  logic [7:0]        default_alpha,
  output logic              out_valid,
  input  logic              out_ready,
  output csscp_pkg::out_t   out_data
);

  logic              out_valid_r;
  csscp_pkg::out_t   out_data_r;
  csscp_pkg::out_t   res;
  logic [2:0][7:0]   comp;
  logic [31:0]       d;

  // floor(255*v/100) for v below 100: reciprocal multiply by 5243 / 2^19
  function automatic logic [7:0] pct_scale(input logic [6:0] v);
    logic [14:0] x;
    logic [27:0] p;
    x = {v, 8'd0} - {8'd0, v};
    p = {13'd0, x} * 28'd5243;
    return p[26:19];
  endfunction

  always_comb begin
    for (int i = 0; i < csscp_pkg::CompCnt; i++) begin
      if (fin.percent_marks[i]) begin
        comp[i] = (fin.comp_values[i] >= 10'd100) ? 8'd255
                                                   : pct_scale(fin.comp_values[i][6:0]);
      end else begin
        comp[i] = (fin.comp_values[i] > 10'd255) ? 8'd255 : fin.comp_values[i][7:0];
      end
    end
  end

  assign d = fin.hex_digits;

  always_comb begin
    res = '0;
    if (fin.form == csscp_pkg::FORM_HEX) begin
      if (fin.hex_count != 4'd3 && fin.hex_count != 4'd6 && fin.hex_count != 4'd8) begin
        res.status = csscp_pkg::ST_HEX_LEN;
      end else if (fin.bad_char) begin
        res.status = csscp_pkg::ST_BAD_CH;
      end else if (fin.hex_count == 4'd3) begin
        // short form: double each digit
        res.red   = {d[11:8], d[11:8]};
        res.green = {d[7:4], d[7:4]};
        res.blue  = {d[3:0], d[3:0]};
        res.alpha = default_alpha;
      end else if (fin.hex_count == 4'd6) begin
        res.red   = d[23:16];
        res.green = d[15:8];
        res.blue  = d[7:0];
        res.alpha = default_alpha;
      end else begin
        res.red   = d[31:24];
        res.green = d[23:16];
        res.blue  = d[15:8];
        res.alpha = d[7:0];
      end
    end else if (fin.form == csscp_pkg::FORM_BODY) begin
      if (fin.bad_char) begin
        res.status = csscp_pkg::ST_BAD_CH;
      end else begin
        res.red   = comp[0];
        res.green = comp[1];
        res.blue  = comp[2];
        res.alpha = default_alpha;
      end
    end else begin
      res.status = csscp_pkg::ST_UNSUP;
    end
  end

  assign fin_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_valid && fin_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      out_data_r <= res;
    end
  end

endmodule

[src/css_color_string_parser_core.sv]
`timescale 1ns / 1ps
// The color reaches out_* through the snapshot register, which loads with the
// final character's transaction, and then through the output register.
// Throughput: one character per cycle; the input stalls only while the snapshot
// and output registers both hold a result and out_ready is low.
// Reset: synchronous active-low rst_n clears the parser state, both valid
// flags and default_alpha.
// ----------------------------------------------------------------------------
// css_color_string_parser_core: CSS hex and rgb() color string parser
// Takes one character per transaction and returns one color and status per
// string, on the character flagged as last.
// ----------------------------------------------------------------------------
module css_color_string_parser_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csscp_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output csscp_pkg::out_t   out_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  logic              fin_valid;
  logic              fin_ready;
  csscp_pkg::fin_t   fin;
  logic [7:0]        default_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_alpha_r <= 8'd0;
    end else if (cfg_we) begin
      default_alpha_r <= cfg_wdata;
    end
  end

  csscp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  csscp_finish u_finish (
    .clk           (clk),
    .rst_n         (rst_n),
    .fin_valid     (fin_valid),
    .fin_ready     (fin_ready),
    .fin           (fin),
    .default_alpha (default_alpha_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for css_color_string_parser_core
// Streams color strings into the parser one character per transaction and
// checks every returned color and status against a cycle-free parser in this
// bench or, for some hand-picked strings, against a given value. A short list
// of hand-picked strings runs first, then random hex, rgb(), broken-prefix and
// junk strings under several default alphas, with random idle cycles on both
// channels, one long output hold-off and one full drain in mid-phase.
// ----------------------------------------------------------------------------
module tb;

  localparam int CycleLimit   = 200000;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 4;
  localparam int PhaseChars   = 265;
  localparam int MaxReports   = 40;

  localparam csscp_pkg::out_t HexLenRes = {32'h0, csscp_pkg::ST_HEX_LEN};
  localparam csscp_pkg::out_t BadChRes  = {32'h0, csscp_pkg::ST_BAD_CH};
  localparam csscp_pkg::out_t UnsupRes  = {32'h0, csscp_pkg::ST_UNSUP};

  typedef enum logic [1:0] {NUM_IDLE, NUM_WHOLE, NUM_FRAC, NUM_EXTRA} num_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  csscp_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  csscp_pkg::out_t out_data;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  css_color_string_parser_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser mirror
  logic [7:0]  alpha_q;
  logic [2:0]  form_q;
  logic [1:0]  prefix_q;
  logic [3:0]  hexcnt_q;
  logic [31:0] hex_q;
  logic        bad_q;
  logic [1:0]  comp_idx_q;
  logic [9:0]  comp_q [3];
  num_mode_t   mode_q;
  logic [2:0]  pct_q;

  csscp_pkg::out_t color_q [$];
  logic [7:0] text_q [$];

  string dir_text [$];
  bit    dir_typed [$];
  csscp_pkg::out_t dir_want [$];

  string hex_set = "0123456789abcdefABCDEF";
  string gap_set = " ,\011\012\015\013\014()rgb";

  bit   typed_on;
  csscp_pkg::out_t typed_val;
  bit   tx_steady;
  bit   hold_req;
  int   sent_cnt;
  int   err_cnt;
  int   cycle_cnt = 0;

  function automatic void clear_parse_state();
    form_q     = csscp_pkg::FORM_START;
    prefix_q   = 2'd0;
    hexcnt_q   = 4'd0;
    hex_q      = 32'd0;
    bad_q      = 1'b0;
    comp_idx_q = 2'd0;
    for (int i = 0; i < 3; i++) comp_q[i] = 10'd0;
    mode_q     = NUM_IDLE;
    pct_q      = 3'd0;
  endfunction

  function automatic void open_number(num_mode_t m, logic [3:0] first);
    if (comp_idx_q < 2'd3) begin
      comp_q[comp_idx_q] = {6'd0, first};
      comp_idx_q++;
      mode_q = m;
    end else begin
      mode_q = NUM_EXTRA;
    end
  endfunction

  // Advance the mirror by one character; returns 1 with the color on the last one
  function automatic bit color_step(input logic [7:0] c, input logic lst,
                                    output csscp_pkg::out_t res);
    logic [3:0] nib;
    logic [7:0] chan [3];
    int v;
    res = '0;
    case (form_q)
      csscp_pkg::FORM_START: begin
        if (c == "#") form_q = csscp_pkg::FORM_HEX;
        else if (c == "r") begin
          form_q   = csscp_pkg::FORM_PREFIX;
          prefix_q = 2'd1;
        end else form_q = csscp_pkg::FORM_UNSUP;
      end
      csscp_pkg::FORM_HEX: begin
        if (c >= "0" && c <= "9") nib = 4'(c - "0");
        else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
        else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
        else begin
          nib   = 4'd0;
          bad_q = 1'b1;
        end
        hex_q = {hex_q[27:0], nib};
        if (hexcnt_q != 4'd15) hexcnt_q++;
      end
      csscp_pkg::FORM_PREFIX: begin
        if (prefix_q == 2'd1 && c == "g") prefix_q = 2'd2;
        else if (prefix_q == 2'd2 && c == "b") begin
          prefix_q = 2'd3;
          form_q   = csscp_pkg::FORM_BODY;
        end else form_q = csscp_pkg::FORM_UNSUP;
      end
      csscp_pkg::FORM_BODY: begin
        if (c >= "0" && c <= "9") begin
          if (mode_q == NUM_IDLE) open_number(NUM_WHOLE, 4'(c - "0"));
          else if (mode_q == NUM_WHOLE) begin
            v = comp_q[comp_idx_q - 2'd1] * 10 + (c - "0");
            comp_q[comp_idx_q - 2'd1] = (v > 1023) ? 10'd1023 : v[9:0];
          end
        end else if (c == ".") begin
          if (mode_q == NUM_WHOLE) mode_q = NUM_FRAC;
          else if (mode_q != NUM_EXTRA) open_number(NUM_FRAC, 4'd0);
        end else if (c == "%") begin
          // percent binds only to a number still in progress
          if (mode_q == NUM_WHOLE || mode_q == NUM_FRAC) pct_q[comp_idx_q - 2'd1] = 1'b1;
          mode_q = NUM_IDLE;
        end else if (c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C,
                               "(", ")", ",", "r", "g", "b"}) begin
          mode_q = NUM_IDLE;
        end else begin
          bad_q  = 1'b1;
          mode_q = NUM_IDLE;
        end
      end
      default: ;
    endcase

    if (!lst) return 1'b0;

    res.status = csscp_pkg::ST_OK;
    if (form_q == csscp_pkg::FORM_HEX) begin
      if (hexcnt_q != 4'd3 && hexcnt_q != 4'd6 && hexcnt_q != 4'd8)
        res.status = csscp_pkg::ST_HEX_LEN;
      else if (bad_q) res.status = csscp_pkg::ST_BAD_CH;
      else if (hexcnt_q == 4'd3) begin
        res.red   = {2{hex_q[11:8]}};
        res.green = {2{hex_q[7:4]}};
        res.blue  = {2{hex_q[3:0]}};
        res.alpha = alpha_q;
      end else if (hexcnt_q == 4'd6) begin
        res.red   = hex_q[23:16];
        res.green = hex_q[15:8];
        res.blue  = hex_q[7:0];
        res.alpha = alpha_q;
      end else begin
        res.red   = hex_q[31:24];
        res.green = hex_q[23:16];
        res.blue  = hex_q[15:8];
        res.alpha = hex_q[7:0];
      end
    end else if (form_q == csscp_pkg::FORM_BODY) begin
      if (bad_q) res.status = csscp_pkg::ST_BAD_CH;
      else begin
        for (int i = 0; i < 3; i++) begin
          v = comp_q[i];
          if (pct_q[i]) v = (255 * v) / 100;
          chan[i] = (v > 255) ? 8'd255 : v[7:0];
        end
        res.red   = chan[0];
        res.green = chan[1];
        res.blue  = chan[2];
        res.alpha = alpha_q;
      end
    end else begin
      res.status = csscp_pkg::ST_UNSUP;
    end
    clear_parse_state();
    return 1'b1;
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      if (err_cnt < MaxReports)
        $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  task automatic add_case(input string s, input bit typed, input csscp_pkg::out_t want);
    dir_text.push_back(s);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endtask

  task automatic write_alpha(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    alpha_q = v;
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_char(input logic [7:0] c, input logic lst);
    int gap;
    csscp_pkg::out_t res;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= csscp_pkg::in_t'{ch: c, last: lst};
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (color_step(c, lst, res)) color_q.push_back(typed_on ? typed_val : res);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic put_number();
    int v;
    string digits;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 255);
      1: v = $urandom_range(0, 100);
      2: v = $urandom_range(0, 9);
      default: v = $urandom_range(0, 99999);
    endcase
    digits = $sformatf("%0d", v);
    if ($urandom_range(0, 9) != 0)
      for (int i = 0; i < digits.len(); i++) text_q.push_back(digits[i]);
    if ($urandom_range(0, 3) == 0) begin
      text_q.push_back(".");
      repeat ($urandom_range(0, 3)) text_q.push_back(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) text_q.push_back(".");
    end
    if ($urandom_range(0, 2) == 0) text_q.push_back("%");
  endtask

  task automatic compose_text();
    int n;
    text_q.delete();
    tx_steady = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        text_q.push_back("#");
        case ($urandom_range(0, 4))
          0: n = 3;
          1: n = 6;
          2: n = 8;
          3: n = $urandom_range(0, 18);
          default: n = $urandom_range(0, 1) ? 3 : 8;
        endcase
        repeat (n) text_q.push_back(hex_set[$urandom_range(0, 21)]);
        if (n != 0 && $urandom_range(0, 5) == 0)
          text_q[$urandom_range(1, n)] = 8'($urandom_range(0, 255));
      end
      3, 4, 5, 6, 7: begin
        text_q.push_back("r");
        text_q.push_back("g");
        text_q.push_back("b");
        if ($urandom_range(0, 3) != 0) text_q.push_back("(");
        n = ($urandom_range(0, 3) != 0) ? 3 : $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
          if (i != 0)
            repeat ($urandom_range(1, 2)) text_q.push_back(gap_set[$urandom_range(0, 11)]);
          put_number();
        end
        if ($urandom_range(0, 3) != 0) text_q.push_back(")");
        if ($urandom_range(0, 7) == 0)
          text_q.insert($urandom_range(3, text_q.size()), 8'($urandom_range(0, 255)));
      end
      8: begin
        text_q.push_back("r");
        if ($urandom_range(0, 1)) text_q.push_back("g");
        repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 2))
          0: text_q[0] = "#";
          1: text_q[0] = "r";
          default: ;
        endcase
      end
    endcase
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : color_sink
    int stall;
    int quiet_left;
    csscp_pkg::out_t want;
    out_ready <= 1'b0;
    quiet_left = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if (quiet_left > 0) begin
        stall = 0;
        quiet_left--;
      end else begin
        stall = $urandom_range(0, 5);
        if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(5, 30);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (color_q.size() == 0) begin
        if (err_cnt < MaxReports)
          $display("%0t: unexpected transaction, got %h", $time, out_data);
        err_cnt++;
      end else begin
        want = color_q.pop_front();
        check_field("red", want.red, out_data.red);
        check_field("green", want.green, out_data.green);
        check_field("blue", want.blue, out_data.blue);
        check_field("alpha", want.alpha, out_data.alpha);
        check_field("status", 8'(want.status), 8'(out_data.status));
      end
    end
  end

  initial begin : stim
    string s;
    int goal;
    bit hold_done;
    bit pause_done;
    logic [7:0] next_alpha;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    err_cnt   = 0;
    sent_cnt  = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    typed_on  = 1'b0;
    tx_steady = 1'b0;
    alpha_q   = 8'd0;
    clear_parse_state();

    add_case("#fff",               1'b1, {8'hFF, 8'hFF, 8'hFF, 8'h80, csscp_pkg::ST_OK});
    add_case("#000000",            1'b1, {8'h00, 8'h00, 8'h00, 8'h80, csscp_pkg::ST_OK});
    add_case("#FFFFFFFF",          1'b1, {8'hFF, 8'hFF, 8'hFF, 8'hFF, csscp_pkg::ST_OK});
    add_case("#00000000",          1'b1, {8'h00, 8'h00, 8'h00, 8'h00, csscp_pkg::ST_OK});
    add_case("#a1B2c3",            1'b1, {8'hA1, 8'hB2, 8'hC3, 8'h80, csscp_pkg::ST_OK});
    add_case("#12345",             1'b1, HexLenRes);
    add_case("#",                  1'b1, HexLenRes);
    add_case("#0123456789abcdef0", 1'b1, HexLenRes);
    add_case("#12g",               1'b1, BadChRes);
    add_case("#1#2",               1'b1, BadChRes);
    add_case("#12g4",              1'b1, HexLenRes);
    add_case("rgb(255,0,128)",     1'b0, '0);
    add_case("rgb(100%, 50.9%, 0%)", 1'b0, '0);
    add_case("rgb(1.5 .7 99999)",  1'b0, '0);
    add_case("rgb(1,2,3,4%)",      1'b0, '0);
    add_case("rgb(%12%)",          1'b0, '0);
    add_case("rgb(1..2)",          1'b0, '0);
    add_case("rgb\011(\01212\015\013\01433)", 1'b0, '0);
    add_case("rgb1g2b3",           1'b0, '0);
    add_case("rgb",                1'b0, '0);
    add_case("rgb(-1,2,3)",        1'b1, BadChRes);
    add_case("rg",                 1'b1, UnsupRes);
    add_case("r",                  1'b1, UnsupRes);
    add_case("rxb(1,2,3)",         1'b1, UnsupRes);
    add_case("hsl(1,2,3)",         1'b1, UnsupRes);
    add_case("\377",               1'b1, UnsupRes);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_alpha(8'h80);

    foreach (dir_text[k]) begin
      s = dir_text[k];
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      typed_on  = dir_typed[k];
      typed_val = dir_want[k];
      send_text();
    end
    typed_on = 1'b0;
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: next_alpha = 8'h00;
        1: next_alpha = 8'hFF;
        default: next_alpha = 8'($urandom_range(1, 254));
      endcase
      write_alpha(next_alpha);
      goal = sent_cnt + PhaseChars;
      while (sent_cnt < goal) begin
        compose_text();
        send_text();
        // back up the output while strings keep coming
        if (ph == 2 && !hold_done && sent_cnt > goal - 200) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if (ph == 3 && !pause_done && sent_cnt > goal - 150) begin
          drain_results();
          pause_done = 1'b1;
        end
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
